>>> hw/rtl/clx_pkg.sv
// Shared types, token codes and character tables for the C subset lexer.
package clx_pkg;

  // Token kind codes
  localparam logic [5:0] KIND_UNDEF  = 6'd0;
  localparam logic [5:0] KIND_PLUS   = 6'd12;
  localparam logic [5:0] KIND_MINUS  = 6'd13;
  localparam logic [5:0] KIND_STAR   = 6'd14;
  localparam logic [5:0] KIND_SLASH  = 6'd15;
  localparam logic [5:0] KIND_ASSIGN = 6'd16;
  localparam logic [5:0] KIND_EQ     = 6'd17;
  localparam logic [5:0] KIND_LT     = 6'd18;
  localparam logic [5:0] KIND_LE     = 6'd19;
  localparam logic [5:0] KIND_GT     = 6'd20;
  localparam logic [5:0] KIND_GE     = 6'd21;
  localparam logic [5:0] KIND_LPAREN = 6'd22;
  localparam logic [5:0] KIND_RPAREN = 6'd23;
  localparam logic [5:0] KIND_LBRACK = 6'd24;
  localparam logic [5:0] KIND_RBRACK = 6'd25;
  localparam logic [5:0] KIND_LBRACE = 6'd26;
  localparam logic [5:0] KIND_RBRACE = 6'd27;
  localparam logic [5:0] KIND_COMMA  = 6'd28;
  localparam logic [5:0] KIND_SEMI   = 6'd29;
  localparam logic [5:0] KIND_INT    = 6'd30;
  localparam logic [5:0] KIND_DOUBLE = 6'd31;
  localparam logic [5:0] KIND_IDENT  = 6'd32;

  // Pending operator codes
  localparam logic [1:0] POP_NONE   = 2'd0;
  localparam logic [1:0] POP_ASSIGN = 2'd1;
  localparam logic [1:0] POP_LT     = 2'd2;
  localparam logic [1:0] POP_GT     = 2'd3;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Keyword table: text packed first character in the low byte, zero padded
  localparam int KEYWORD_COUNT = 11;
  localparam int KW_CHARS      = 6;
  localparam int KW_BITS       = KW_CHARS * 8;

  localparam logic [KW_BITS-1:0] KW_TEXT [KEYWORD_COUNT] = '{
    48'h0000_6469_6f76,  // void
    48'h0000_6e69_616d,  // main
    48'h0000_0074_6e69,  // int
    48'h656c_6275_6f64,  // double
    48'h0000_0072_6f66,  // for
    48'h0065_6c69_6877,  // while
    48'h6863_7469_7773,  // switch
    48'h0000_6573_6163,  // case
    48'h0000_0000_6669,  // if
    48'h0000_6573_6c65,  // else
    48'h6e72_7574_6572   // return
  };
  localparam logic [7:0] KW_LEN [KEYWORD_COUNT] = '{
    8'd4, 8'd4, 8'd3, 8'd6, 8'd3, 8'd5, 8'd6, 8'd4, 8'd2, 8'd4, 8'd6
  };

  // Output token FIFO
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int MAX_TOKENS = 3;
  localparam int LINE_OUT_W = 16;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_INT    = 3'd2,
    MODE_INTDOT = 3'd3,
    MODE_FRAC   = 3'd4,
    MODE_OP     = 3'd5
  } mode_t;

  typedef struct packed {
    logic [5:0]            kind;
    logic [LINE_OUT_W-1:0] line;
    logic [7:0]            len;
    logic [31:0]           val;
    logic                  last;
  } token_t;

  // Tokens produced by one request, in order
  typedef struct packed {
    logic [1:0]                  cnt;
    token_t [MAX_TOKENS-1:0]     tok;
  } push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Word kind: keyword code or identifier
  function automatic logic [5:0] kw_kind(input logic [KW_BITS-1:0] prefix,
                                         input logic [7:0] len);
    logic [5:0] k;
    k = KIND_IDENT;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (len == KW_LEN[i] && prefix == KW_TEXT[i]) k = 6'(i + 1);
    end
    return k;
  endfunction

  // Single character operators and separators
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2A:   k = KIND_STAR;
      8'h2F:   k = KIND_SLASH;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h2C:   k = KIND_COMMA;
      8'h3B:   k = KIND_SEMI;
      default: k = KIND_UNDEF;
    endcase
    return k;
  endfunction

endpackage

>>> hw/rtl/clx_core.sv
// Lexer core: input register, scan state and per-byte token generation.
module clx_core #(
  parameter int KEYWORD_MAX_CHARS = 6,
  parameter int LINE_BITS         = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_flush,
  output logic           stg_vld,
  output clx_pkg::push_t push
);
  import clx_pkg::*;

  localparam int PIX_W = $clog2(KEYWORD_MAX_CHARS);

  // Input register
  logic       stg_vld_r;
  logic [7:0] stg_byte_r;
  logic       stg_flush_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_byte_r  <= in_byte;
      stg_flush_r <= in_flush;
    end
  end

  assign stg_vld = stg_vld_r;

  // Scan state
  mode_t                 mode_r, mode_nxt;
  logic [1:0]            pop_r, pop_nxt;
  logic [7:0]            prefix_r [KEYWORD_MAX_CHARS];
  logic [7:0]            prefix_nxt [KEYWORD_MAX_CHARS];
  logic [7:0]            len_r, len_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pop_r  <= POP_NONE;
      len_r  <= '0;
      acc_r  <= '0;
      line_r <= LINE_BITS'(1);
      for (int i = 0; i < KEYWORD_MAX_CHARS; i++) prefix_r[i] <= '0;
    end else if (stg_vld_r) begin
      mode_r <= mode_nxt;
      pop_r  <= pop_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      line_r <= line_nxt;
      for (int i = 0; i < KEYWORD_MAX_CHARS; i++) prefix_r[i] <= prefix_nxt[i];
    end
  end

  // Line number as reported on tokens
  logic [LINE_OUT_W-1:0] line16;
  generate
    if (LINE_BITS >= LINE_OUT_W) begin : g_line_cut
      assign line16 = line_r[LINE_OUT_W-1:0];
    end else begin : g_line_ext
      assign line16 = {{(LINE_OUT_W - LINE_BITS){1'b0}}, line_r};
    end
  endgenerate

  // Keyword compare window over the first characters of the word
  logic [KW_BITS-1:0] kw_win;
  always_comb begin
    for (int i = 0; i < KW_CHARS; i++) kw_win[i*8 +: 8] = prefix_r[i];
  end

  // Integer accumulate: acc * 10 + digit, saturating
  logic [35:0] acc_mul;
  logic [31:0] acc_sat;
  logic [7:0]  digit;
  assign digit   = stg_byte_r - CH_ZERO;
  assign acc_mul = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {28'd0, digit};
  assign acc_sat = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_mul[31:0];

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [1:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {7'd0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic token_t mk_tok(input logic [5:0] kind, input logic [7:0] len,
                                    input logic [31:0] val,
                                    input logic [LINE_OUT_W-1:0] line);
    token_t t;
    t.kind = kind;
    t.line = line;
    t.len  = len;
    t.val  = val;
    t.last = 1'b0;
    return t;
  endfunction

  // Next state and tokens for the staged byte
  always_comb begin
    logic [7:0] c;
    logic       finish;
    logic       clear;
    logic       fresh;
    logic [1:0] n;
    c      = stg_byte_r;
    finish = 1'b0;
    clear  = 1'b0;
    fresh  = 1'b0;
    n      = 2'd0;
    push   = '0;

    mode_nxt = mode_r;
    pop_nxt  = pop_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    line_nxt = line_r;
    for (int i = 0; i < KEYWORD_MAX_CHARS; i++) prefix_nxt[i] = prefix_r[i];

    // Continue or end the current run
    if (stg_flush_r) begin
      finish = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_WORD: begin
          if (is_letter(c) || is_digit(c)) begin
            if (len_r < 8'(KEYWORD_MAX_CHARS)) prefix_nxt[len_r[PIX_W-1:0]] = c;
            len_nxt = sat_add(len_r, 2'd1);
          end else begin
            finish = 1'b1;
            fresh  = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            acc_nxt = acc_sat;
            len_nxt = sat_add(len_r, 2'd1);
          end else if (c == CH_DOT) begin
            mode_nxt = MODE_INTDOT;
          end else begin
            finish = 1'b1;
            fresh  = 1'b1;
          end
        end
        MODE_INTDOT: begin
          if (is_digit(c)) begin
            mode_nxt = MODE_FRAC;
            len_nxt  = sat_add(len_r, 2'd2);
          end else begin
            finish = 1'b1;
            fresh  = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(c)) begin
            len_nxt = sat_add(len_r, 2'd1);
          end else begin
            finish = 1'b1;
            fresh  = 1'b1;
          end
        end
        MODE_OP: begin
          // Two-character comparison operator
          if (c == CH_EQ && pop_r != POP_NONE) begin
            case (pop_r)
              POP_ASSIGN: push.tok[n] = mk_tok(KIND_EQ, 8'd2, 32'd0, line16);
              POP_LT:     push.tok[n] = mk_tok(KIND_LE, 8'd2, 32'd0, line16);
              default:    push.tok[n] = mk_tok(KIND_GE, 8'd2, 32'd0, line16);
            endcase
            n     = n + 2'd1;
            clear = 1'b1;
          end else begin
            finish = 1'b1;
            fresh  = 1'b1;
          end
        end
        default: begin
          clear = 1'b1;
          fresh = 1'b1;
        end
      endcase
    end

    // Emit the pending token(s)
    if (finish) begin
      clear = 1'b1;
      unique case (mode_r)
        MODE_WORD: begin
          push.tok[n] = mk_tok(kw_kind(kw_win, len_r), len_r, 32'd0, line16);
          n = n + 2'd1;
        end
        MODE_INT: begin
          push.tok[n] = mk_tok(KIND_INT, len_r, acc_r, line16);
          n = n + 2'd1;
        end
        MODE_INTDOT: begin
          // Dot without a following digit becomes its own token
          push.tok[n] = mk_tok(KIND_INT, len_r, acc_r, line16);
          n = n + 2'd1;
          push.tok[n] = mk_tok(KIND_UNDEF, 8'd1, 32'd0, line16);
          n = n + 2'd1;
        end
        MODE_FRAC: begin
          push.tok[n] = mk_tok(KIND_DOUBLE, len_r, 32'd0, line16);
          n = n + 2'd1;
        end
        MODE_OP: begin
          case (pop_r)
            POP_ASSIGN: push.tok[n] = mk_tok(KIND_ASSIGN, 8'd1, 32'd0, line16);
            POP_LT:     push.tok[n] = mk_tok(KIND_LT, 8'd1, 32'd0, line16);
            POP_GT:     push.tok[n] = mk_tok(KIND_GT, 8'd1, 32'd0, line16);
            default:    push.tok[n] = mk_tok(KIND_UNDEF, 8'd1, 32'd0, line16);
          endcase
          n = n + 2'd1;
        end
        default: ;
      endcase
    end

    if (clear) begin
      mode_nxt = MODE_IDLE;
      pop_nxt  = POP_NONE;
      len_nxt  = '0;
      acc_nxt  = '0;
      for (int i = 0; i < KEYWORD_MAX_CHARS; i++) prefix_nxt[i] = '0;
    end

    // Start a new run from this byte
    if (fresh) begin
      if (c == CH_SPACE || c == CH_TAB) begin
        // skipped
      end else if (c == CH_NL) begin
        if (line_r != '1) line_nxt = line_r + LINE_BITS'(1);
      end else if (is_letter(c)) begin
        mode_nxt      = MODE_WORD;
        prefix_nxt[0] = c;
        len_nxt       = 8'd1;
      end else if (is_digit(c)) begin
        mode_nxt = MODE_INT;
        acc_nxt  = {24'd0, digit};
        len_nxt  = 8'd1;
      end else if (c == CH_EQ || c == CH_LT || c == CH_GT) begin
        mode_nxt = MODE_OP;
        pop_nxt  = (c == CH_EQ) ? POP_ASSIGN : (c == CH_LT) ? POP_LT : POP_GT;
        len_nxt  = 8'd1;
      end else begin
        push.tok[n] = mk_tok(single_kind(c), 8'd1, 32'd0, line16);
        n = n + 2'd1;
      end
    end

    // Flag the final token of this request
    if (n != 2'd0) push.tok[n - 2'd1].last = 1'b1;
    push.cnt = stg_vld_r ? n : 2'd0;
  end

endmodule

>>> hw/rtl/clx_fifo.sv
// Token FIFO: takes up to three tokens per cycle, delivers one per cycle.
module clx_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  clx_pkg::push_t               push,
  input  logic                         pop,
  output logic                         head_vld,
  output clx_pkg::token_t              head,
  output logic [clx_pkg::CNT_W-1:0]    count
);
  import clx_pkg::*;

  token_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign count_nxt = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TOKENS; k++) begin
      if (2'(k) < push.cnt) mem[wr_ptr_r + PTR_W'(k)] <= push.tok[k];
    end
  end

  assign head_vld = (count_r != '0);
  assign head     = mem[rd_ptr_r];
  assign count    = count_r;

endmodule

>>> hw/rtl/c_subset_lexer.sv
// Top level of the streaming C subset lexer.
//
// Source bytes enter on in_valid/in_ready with in_byte and in_flush; in_flush
// marks end of input and pushes out any pending token (in_byte is then unused).
// Tokens leave on out_valid/out_ready, one per cycle, with kind, line number,
// length, integer value and last_of_run, which flags the last token caused by
// one input request.
// Throughput: one byte per cycle while in_ready is high. A byte is first held
// in the input register, then its tokens (zero to three) are written into an
// eight-entry token FIFO, from whose head they are delivered. Since a token
// usually ends one byte after its last character, tokens appear about one byte
// behind the source.
// in_ready stays high while the FIFO has room for the worst case of the byte
// in flight plus a new byte (three tokens each). When the receiver stalls the
// FIFO fills and in_ready drops; tokens are never lost.
// Reset (synchronous, rst_n low) empties the FIFO, clears the scanner and sets
// the line counter to one.
module c_subset_lexer #(
  parameter int KEYWORD_MAX_CHARS = 6,
  parameter int LINE_BITS         = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_flush,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_line_number,
  output logic [7:0]  out_token_length,
  output logic [31:0] out_int_value,
  output logic        out_last_of_run
);
  import clx_pkg::*;

  logic             accept;
  logic             stg_vld;
  push_t            push;
  token_t           head;
  logic [CNT_W-1:0] count;
  logic [CNT_W+1:0] need;

  // Room for the request in flight and a new one
  assign need     = {2'b00, count} + (stg_vld ? (CNT_W+2)'(MAX_TOKENS) : '0)
                    + (CNT_W+2)'(MAX_TOKENS);
  assign in_ready = (need <= (CNT_W+2)'(FIFO_DEPTH));
  assign accept   = in_valid & in_ready;

  clx_core #(
    .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS),
    .LINE_BITS        (LINE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_flush(in_flush),
    .stg_vld (stg_vld),
    .push    (push)
  );

  clx_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (out_valid & out_ready),
    .head_vld(out_valid),
    .head    (head),
    .count   (count)
  );

  assign out_token_kind   = head.kind;
  assign out_line_number  = head.line;
  assign out_token_length = head.len;
  assign out_int_value    = head.val;
  assign out_last_of_run  = head.last;

`ifndef NO_ASSERTIONS
  // Tokens written never exceed free FIFO space
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count} + (CNT_W+1)'(push.cnt)) <= (CNT_W+1)'(FIFO_DEPTH))
    else $error("token FIFO overflow");

  // An accepted request is processed in the following cycle
  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> stg_vld)
    else $error("accepted byte not staged");

  // Every delivered token has nonzero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_length != 8'd0)
    else $error("token of zero length");

  // Kind codes stay within the defined range
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KIND_IDENT)
    else $error("token kind out of range");
`endif

endmodule
